// ===== rtl/core/nps_pkg.sv =====
// Types, constants and control store for the next-prime search block.
package nps_pkg;

  // Reset value of the search limit register
  localparam logic [30:0] LIMIT_RESET = 31'd2000000000;

  // Condition codes tested by the sequencer
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_IN_VALID,
    C_OUT_FREE,
    C_DIV_BUSY,
    C_LT2,
    C_SQ_GT,
    C_REM_ZERO,
    C_MODE_CAND,
    C_RES_PRIME,
    C_CAND_GE_LIM
  } cond_e;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_INIT_D,
    OP_CLR_REM,
    OP_DIV_STEP,
    OP_NEXT_D,
    OP_SET_PRIME,
    OP_SET_COMP,
    OP_SAVE_VAL,
    OP_CAND_INC,
    OP_LOAD_N,
    OP_EMIT_MISS,
    OP_EMIT_HIT
  } op_e;

  localparam int UpcBits = 4;
  typedef logic [UpcBits-1:0] upc_t;

  // Step addresses
  localparam upc_t UPC_IDLE      = 4'd0;
  localparam upc_t UPC_TEST      = 4'd1;
  localparam upc_t UPC_CHKSQ     = 4'd2;
  localparam upc_t UPC_DIV       = 4'd3;
  localparam upc_t UPC_REMCHK    = 4'd4;
  localparam upc_t UPC_NEXTD     = 4'd5;
  localparam upc_t UPC_PRIME     = 4'd6;
  localparam upc_t UPC_COMP      = 4'd7;
  localparam upc_t UPC_RET       = 4'd8;
  localparam upc_t UPC_VALDONE   = 4'd9;
  localparam upc_t UPC_CANDRES   = 4'd10;
  localparam upc_t UPC_NEXT      = 4'd11;
  localparam upc_t UPC_LOADN     = 4'd12;
  localparam upc_t UPC_DONE_MISS = 4'd13;
  localparam upc_t UPC_DONE_HIT  = 4'd14;

  // One control word: hold until wait_c, run op, then jump to target if br_c else fall through
  typedef struct packed {
    cond_e wait_c;
    op_e   op;
    cond_e br_c;
    upc_t  target;
  } uword_t;

  function automatic uword_t ucode(input upc_t pc);
    uword_t w;
    case (pc)
      UPC_IDLE:      w = '{C_IN_VALID, OP_LOAD,      C_NEVER,       UPC_IDLE};
      UPC_TEST:      w = '{C_ALWAYS,   OP_INIT_D,    C_LT2,         UPC_COMP};
      UPC_CHKSQ:     w = '{C_ALWAYS,   OP_CLR_REM,   C_SQ_GT,       UPC_PRIME};
      UPC_DIV:       w = '{C_ALWAYS,   OP_DIV_STEP,  C_DIV_BUSY,    UPC_DIV};
      UPC_REMCHK:    w = '{C_ALWAYS,   OP_NOP,       C_REM_ZERO,    UPC_COMP};
      UPC_NEXTD:     w = '{C_ALWAYS,   OP_NEXT_D,    C_ALWAYS,      UPC_CHKSQ};
      UPC_PRIME:     w = '{C_ALWAYS,   OP_SET_PRIME, C_ALWAYS,      UPC_RET};
      UPC_COMP:      w = '{C_ALWAYS,   OP_SET_COMP,  C_NEVER,       UPC_RET};
      UPC_RET:       w = '{C_ALWAYS,   OP_NOP,       C_MODE_CAND,   UPC_CANDRES};
      UPC_VALDONE:   w = '{C_ALWAYS,   OP_SAVE_VAL,  C_ALWAYS,      UPC_NEXT};
      UPC_CANDRES:   w = '{C_ALWAYS,   OP_CAND_INC,  C_RES_PRIME,   UPC_DONE_HIT};
      UPC_NEXT:      w = '{C_ALWAYS,   OP_NOP,       C_CAND_GE_LIM, UPC_DONE_MISS};
      UPC_LOADN:     w = '{C_ALWAYS,   OP_LOAD_N,    C_ALWAYS,      UPC_TEST};
      UPC_DONE_MISS: w = '{C_OUT_FREE, OP_EMIT_MISS, C_ALWAYS,      UPC_IDLE};
      UPC_DONE_HIT:  w = '{C_OUT_FREE, OP_EMIT_HIT,  C_ALWAYS,      UPC_IDLE};
      default:       w = '{C_ALWAYS,   OP_NOP,       C_ALWAYS,      UPC_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/next_prime_search_top.sv =====
// Next-prime search: primality test and upward prime search by trial division.
// Each tested number n is tried against up to floor(sqrt(n))-1 trial divisors; a
//   transaction tests the value and then each candidate in turn.
// Throughput: one transaction at a time; the 1-bit-per-cycle remainder unit sets the pace.
// Reset: sequencer to idle, output empty, search limit to 2000000000 (masked to width).
module next_prime_search_top #(
  parameter int VALUE_BITS = 31,
  localparam int LimBits = (VALUE_BITS < 31) ? VALUE_BITS : 31
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  search_limit_we_i,
  input  logic [LimBits-1:0]    search_limit_i,
  // input transaction
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [VALUE_BITS-1:0] value_i,
  // output transaction
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  value_is_prime_o,
  output logic [VALUE_BITS-1:0] next_prime_o,
  output logic                  not_found_o
);

  // Candidate may reach 2^VALUE_BITS, trial divisor stays near sqrt, square one bit over
  localparam int CandBits = VALUE_BITS + 1;
  localparam int DBits    = (VALUE_BITS + 1) / 2 + 1;
  localparam int SqBits   = VALUE_BITS + 2;
  localparam int CntBits  = $clog2(VALUE_BITS);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  nps_pkg::upc_t         pc_q, pc_d;
  logic [LimBits-1:0]    limit_q;
  logic                  out_valid_q, out_valid_d;

  logic [VALUE_BITS-1:0] val_q, val_d;       // value of the transaction
  logic [VALUE_BITS-1:0] n_q, n_d;           // number under test
  logic [CandBits-1:0]   cand_q, cand_d;     // next search candidate
  logic                  mode_q, mode_d;     // 0: testing the value, 1: a candidate
  logic [DBits-1:0]      d_q, d_d;           // trial divisor
  logic [SqBits-1:0]     sq_q, sq_d;         // d squared
  logic [DBits-1:0]      rem_q, rem_d;       // partial remainder
  logic [VALUE_BITS-1:0] shreg_q, shreg_d;   // dividend bits still to shift in
  logic [CntBits-1:0]    cnt_q, cnt_d;
  logic                  res_q, res_d;       // outcome of the last test
  logic                  isprime_q, isprime_d;

  logic                  o_prime_q, o_prime_d;
  logic [VALUE_BITS-1:0] o_next_q, o_next_d;
  logic                  o_nf_q, o_nf_d;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  nps_pkg::uword_t uw;
  logic [15:0]     cond_vec;
  logic            out_free;
  logic            go;
  logic            br_take;

  assign uw       = nps_pkg::ucode(pc_q);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    cond_vec                          = '0;
    cond_vec[nps_pkg::C_NEVER]        = 1'b0;
    cond_vec[nps_pkg::C_ALWAYS]       = 1'b1;
    cond_vec[nps_pkg::C_IN_VALID]     = in_valid_i;
    cond_vec[nps_pkg::C_OUT_FREE]     = out_free;
    cond_vec[nps_pkg::C_DIV_BUSY]     = (cnt_q != CntBits'(VALUE_BITS - 1));
    cond_vec[nps_pkg::C_LT2]          = (n_q < VALUE_BITS'(2));
    cond_vec[nps_pkg::C_SQ_GT]        = (sq_q > SqBits'(n_q));
    cond_vec[nps_pkg::C_REM_ZERO]     = (rem_q == '0);
    cond_vec[nps_pkg::C_MODE_CAND]    = mode_q;
    cond_vec[nps_pkg::C_RES_PRIME]    = res_q;
    cond_vec[nps_pkg::C_CAND_GE_LIM]  = (cand_q >= CandBits'(limit_q));
  end

  assign go      = cond_vec[uw.wait_c];
  assign br_take = cond_vec[uw.br_c];

  always_comb begin
    if (!go) begin
      pc_d = pc_q;
    end else if (br_take) begin
      pc_d = uw.target;
    end else begin
      pc_d = pc_q + nps_pkg::upc_t'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  logic [DBits:0] trial;
  logic [DBits:0] diff;

  // restoring remainder step, one dividend bit per cycle
  assign trial = {rem_q, shreg_q[VALUE_BITS-1]};
  assign diff  = trial - {1'b0, d_q};

  always_comb begin
    val_d       = val_q;
    n_d         = n_q;
    cand_d      = cand_q;
    mode_d      = mode_q;
    d_d         = d_q;
    sq_d        = sq_q;
    rem_d       = rem_q;
    shreg_d     = shreg_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    isprime_d   = isprime_q;
    o_prime_d   = o_prime_q;
    o_next_d    = o_next_q;
    o_nf_d      = o_nf_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (go) begin
      case (uw.op)
        nps_pkg::OP_LOAD: begin
          val_d  = value_i;
          n_d    = value_i;
          mode_d = 1'b0;
        end
        nps_pkg::OP_INIT_D: begin
          d_d  = DBits'(2);
          sq_d = SqBits'(4);
        end
        nps_pkg::OP_CLR_REM: begin
          rem_d   = '0;
          shreg_d = n_q;
          cnt_d   = '0;
        end
        nps_pkg::OP_DIV_STEP: begin
          rem_d   = diff[DBits] ? trial[DBits-1:0] : diff[DBits-1:0];
          shreg_d = {shreg_q[VALUE_BITS-2:0], 1'b0};
          cnt_d   = cnt_q + CntBits'(1);
        end
        nps_pkg::OP_NEXT_D: begin
          // (d+1)^2 = d^2 + 2d + 1
          sq_d = sq_q + SqBits'({d_q, 1'b1});
          d_d  = d_q + DBits'(1);
        end
        nps_pkg::OP_SET_PRIME: res_d = 1'b1;
        nps_pkg::OP_SET_COMP:  res_d = 1'b0;
        nps_pkg::OP_SAVE_VAL: begin
          isprime_d = res_q;
          cand_d    = CandBits'(val_q) + CandBits'(1);
          mode_d    = 1'b1;
        end
        nps_pkg::OP_CAND_INC: cand_d = cand_q + CandBits'(1);
        nps_pkg::OP_LOAD_N:   n_d    = cand_q[VALUE_BITS-1:0];
        nps_pkg::OP_EMIT_MISS: begin
          o_prime_d   = isprime_q;
          o_next_d    = '0;
          o_nf_d      = 1'b1;
          out_valid_d = 1'b1;
        end
        nps_pkg::OP_EMIT_HIT: begin
          o_prime_d   = isprime_q;
          o_next_d    = n_q;
          o_nf_d      = 1'b0;
          out_valid_d = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= nps_pkg::UPC_IDLE;
      out_valid_q <= 1'b0;
      limit_q     <= LimBits'(nps_pkg::LIMIT_RESET);
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
      if (search_limit_we_i) begin
        limit_q <= search_limit_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q     <= val_d;
    n_q       <= n_d;
    cand_q    <= cand_d;
    mode_q    <= mode_d;
    d_q       <= d_d;
    sq_q      <= sq_d;
    rem_q     <= rem_d;
    shreg_q   <= shreg_d;
    cnt_q     <= cnt_d;
    res_q     <= res_d;
    isprime_q <= isprime_d;
    o_prime_q <= o_prime_d;
    o_next_q  <= o_next_d;
    o_nf_q    <= o_nf_d;
  end

  assign in_ready_o       = (pc_q == nps_pkg::UPC_IDLE);
  assign out_valid_o      = out_valid_q;
  assign value_is_prime_o = o_prime_q;
  assign next_prime_o     = o_next_q;
  assign not_found_o      = o_nf_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_nf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && not_found_o |-> next_prime_o == '0)
    else $error("not_found with non-zero next_prime");

  a_hit_ge2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !not_found_o |-> next_prime_o >= VALUE_BITS'(2))
    else $error("reported prime below two");

  a_rem_lt_d: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q == nps_pkg::UPC_DIV |-> (rem_q < d_q) && (d_q >= DBits'(2)))
    else $error("partial remainder out of range");

  a_accept_test: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> pc_q == nps_pkg::UPC_TEST)
    else $error("accepted transaction did not start a test");

endmodule
